### rtl/mcac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcac_pkg
// Shared types, constants and the mode-to-state map of the actuator sequencer.
// ----------------------------------------------------------------------------
package mcac_pkg;

    localparam int CH_SLOTS             = 8;   // room in masks and state word
    localparam int CH_W                 = 3;
    localparam int MODE_W               = 3;
    localparam int NUM_CHANNELS_DEFAULT = 8;
    localparam int S_TDATA_W            = 88;
    localparam int M_TDATA_W            = 40;

    // 0.1 A expressed in mA
    localparam logic [15:0] LIMIT_RESET = 16'd100;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_CHECK   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RETRACT_FULL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXTEND_FULL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RETRACT_TIMED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXTEND_TIMED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ON            = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OFF           = 3'd5;

    localparam logic [1:0] REP_RETRACTING = 2'd0;
    localparam logic [1:0] REP_EXTENDING  = 2'd1;
    localparam logic [1:0] REP_OFF        = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [CH_W-1:0]   channel;
        logic [MODE_W-1:0] command;
        logic [31:0]       duration_ms;
        logic [31:0]       now_ms;
        logic [15:0]       current_ma;
    } req_t;

    typedef struct packed {
        logic [7:0]  forward_mask;
        logic [7:0]  reverse_mask;
        logic [15:0] reported_states;
        logic        channel_stopped;
    } res_t;

    function automatic logic [1:0] report_of_mode(input logic [MODE_W-1:0] mode);
        logic [1:0] rep;
        unique case (mode)
            MODE_RETRACT_FULL, MODE_RETRACT_TIMED:        rep = REP_RETRACTING;
            MODE_EXTEND_FULL, MODE_EXTEND_TIMED, MODE_ON: rep = REP_EXTENDING;
            default:                                      rep = REP_OFF;
        endcase
        return rep;
    endfunction

endpackage

### rtl/mcac_channel_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcac_channel_bank
// Per-channel mode, start stamp and run length; applies one word per cycle when
// fire is high and forms the drive masks and reported states from the updated modes.
// ----------------------------------------------------------------------------
module mcac_channel_bank #(
    parameter int NUM_CHANNELS = mcac_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       limit_current_ma,
    input  logic              fire,
    input  mcac_pkg::req_t    req,
    output mcac_pkg::res_t    res
);
    import mcac_pkg::*;

    logic [MODE_W-1:0] mode_reg  [CH_SLOTS];
    logic [MODE_W-1:0] mode_next [CH_SLOTS];
    logic [31:0]       start_reg  [CH_SLOTS];
    logic [31:0]       start_next [CH_SLOTS];
    logic [31:0]       len_reg  [CH_SLOTS];
    logic [31:0]       len_next [CH_SLOTS];

    logic              present;
    logic [MODE_W-1:0] cur_mode;
    logic [31:0]       elapsed;
    logic              stopped;

    assign present  = (32'(req.channel) < NUM_CHANNELS);
    assign cur_mode = mode_reg[req.channel];
    // wrapping elapsed time
    assign elapsed  = req.now_ms - start_reg[req.channel];

    always_comb
    begin
        for (int i = 0; i < CH_SLOTS; i++)
        begin
            mode_next[i]  = mode_reg[i];
            start_next[i] = start_reg[i];
            len_next[i]   = len_reg[i];
        end
        stopped = 1'b0;
        if (fire && present)
        begin
            if (req.opcode == OP_COMMAND)
            begin
                mode_next[req.channel]  = (req.command <= MODE_OFF) ? req.command : MODE_OFF;
                start_next[req.channel] = req.now_ms;
                len_next[req.channel]   = req.duration_ms;
            end
            else
            begin
                unique case (cur_mode)
                    MODE_RETRACT_FULL, MODE_EXTEND_FULL:
                    begin
                        if (req.current_ma < limit_current_ma)
                        begin
                            mode_next[req.channel] = MODE_OFF;
                            stopped = 1'b1;
                        end
                    end
                    MODE_RETRACT_TIMED, MODE_EXTEND_TIMED:
                    begin
                        if (elapsed > len_reg[req.channel])
                        begin
                            mode_next[req.channel] = MODE_OFF;
                            len_next[req.channel]  = '0;
                            stopped = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res = '0;
        res.channel_stopped = stopped;
        for (int i = 0; i < CH_SLOTS; i++)
        begin
            if (i < NUM_CHANNELS)
            begin
                res.forward_mask[i] = (mode_next[i] == MODE_EXTEND_FULL) ||
                                      (mode_next[i] == MODE_EXTEND_TIMED) ||
                                      (mode_next[i] == MODE_ON);
                res.reverse_mask[i] = (mode_next[i] == MODE_RETRACT_FULL) ||
                                      (mode_next[i] == MODE_RETRACT_TIMED);
                res.reported_states[2*i +: 2] = report_of_mode(mode_next[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                mode_reg[i]  <= MODE_OFF;
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                mode_reg[i]  <= mode_next[i];
                start_reg[i] <= start_next[i];
                len_reg[i]   <= len_next[i];
            end
        end
    end

endmodule

### rtl/multi_channel_actuator_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_actuator_controller
// Per-channel linear actuator sequencer with command and check words.
// ----------------------------------------------------------------------------
// Path: an accepted word enters the input register, then its channel update
// is written into the result register once that register can advance.
// Throughput: one word per cycle unless m_tready stalls the result register.
// Reset: all channels off, stamps and lengths zero, current limit 100 mA,
// both pipeline stages empty.
module multi_channel_actuator_controller #(
    parameter int NUM_CHANNELS = mcac_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [15:0]                    cfg_wr_data,  // limit_current_ma
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // channel[2:0], command[5:3], duration_ms[37:6], now_ms[69:38],
    // current_ma[85:70], zero pad
    input  logic [mcac_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,      // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // forward_mask[7:0], reverse_mask[15:8], reported_states[31:16],
    // channel_stopped[32], zero pad
    output logic [mcac_pkg::M_TDATA_W-1:0] m_tdata
);
    import mcac_pkg::*;

    logic [15:0] limit_reg;
    logic        in_valid_reg;
    req_t        in_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    res_t        bank_res;
    logic        out_adv;
    logic        stage_fire;
    req_t        s_req;

    assign out_adv    = !out_valid_reg || m_tready;
    assign stage_fire = in_valid_reg && out_adv;
    assign s_tready   = !in_valid_reg || out_adv;

    always_comb
    begin
        s_req.opcode      = s_tuser[0];
        s_req.channel     = s_tdata[2:0];
        s_req.command     = s_tdata[5:3];
        s_req.duration_ms = s_tdata[37:6];
        s_req.now_ms      = s_tdata[69:38];
        s_req.current_ma  = s_tdata[85:70];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= s_req;
        if (stage_fire)
            out_reg <= bank_res;
    end

    mcac_channel_bank #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_bank (
        .clk              (clk),
        .rst_n            (rst_n),
        .limit_current_ma (limit_reg),
        .fire             (stage_fire),
        .req              (in_reg),
        .res              (bank_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.channel_stopped, out_reg.reported_states,
                       out_reg.reverse_mask, out_reg.forward_mask};

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for multi_channel_actuator_controller
// Drives command and check words over the input stream and predicts the
// drive masks, reported states and stop flag of every result word. The
// expected words are compared field by field. The current limit is swept
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import mcac_pkg::*;

    typedef struct {
        logic [7:0]  forward_mask;
        logic [7:0]  reverse_mask;
        logic [15:0] reported_states;
        logic        channel_stopped;
    } act_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    multi_channel_actuator_controller u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // channel bank mirror
    logic [MODE_W-1:0] mode_of [CH_SLOTS];
    logic [31:0]       start_of [CH_SLOTS];
    logic [31:0]       length_of [CH_SLOTS];
    logic [15:0]       limit_ma = LIMIT_RESET;

    req_t        word_q [$];
    act_status_t status_q [$];
    req_t        on_wire;

    int n_queued = 0;
    int n_commands = 0;
    int n_checks = 0;
    int n_full_stops = 0;
    int n_timed_stops = 0;
    int n_results = 0;
    int n_limits = 0;
    int errors = 0;

    initial
    begin
        for (int i = 0; i < CH_SLOTS; i++)
        begin
            mode_of[i] = MODE_OFF;
            start_of[i] = '0;
            length_of[i] = '0;
        end
    end

    // Apply one word to the mirrored bank and build the status it returns.
    function automatic act_status_t step_channels(input req_t w);
        act_status_t r;
        logic [MODE_W-1:0] m;
        logic [31:0] elapsed;
        r.forward_mask = '0;
        r.reverse_mask = '0;
        r.reported_states = '0;
        r.channel_stopped = 1'b0;
        if (w.opcode == OP_COMMAND)
        begin
            n_commands++;
            mode_of[w.channel] = (w.command > MODE_OFF) ? MODE_OFF : w.command;
            start_of[w.channel] = w.now_ms;
            length_of[w.channel] = w.duration_ms;
        end
        else
        begin
            n_checks++;
            m = mode_of[w.channel];
            elapsed = w.now_ms - start_of[w.channel];
            if (m == MODE_RETRACT_FULL || m == MODE_EXTEND_FULL)
            begin
                if (w.current_ma < limit_ma)
                begin
                    mode_of[w.channel] = MODE_OFF;
                    r.channel_stopped = 1'b1;
                    n_full_stops++;
                end
            end
            else if (m == MODE_RETRACT_TIMED || m == MODE_EXTEND_TIMED)
            begin
                if (elapsed > length_of[w.channel])
                begin
                    length_of[w.channel] = '0;
                    mode_of[w.channel] = MODE_OFF;
                    r.channel_stopped = 1'b1;
                    n_timed_stops++;
                end
            end
        end
        for (int i = 0; i < CH_SLOTS; i++)
        begin
            case (mode_of[i])
                MODE_RETRACT_FULL, MODE_RETRACT_TIMED:
                begin
                    r.reverse_mask[i] = 1'b1;
                    r.reported_states[2*i +: 2] = REP_RETRACTING;
                end
                MODE_EXTEND_FULL, MODE_EXTEND_TIMED, MODE_ON:
                begin
                    r.forward_mask[i] = 1'b1;
                    r.reported_states[2*i +: 2] = REP_EXTENDING;
                end
                default:
                    r.reported_states[2*i +: 2] = REP_OFF;
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, random gaps, some bursts gap-free
    // ------------------------------------------------------------------------
    int  burst_left = 0;
    int  gap_left = 0;
    logic valid_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_q.push_back(step_channels(on_wire));
            if (!s_tvalid || s_tready)
            begin
                valid_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (word_q.size() > 0)
                begin
                    on_wire = word_q.pop_front();
                    valid_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= valid_next;
                s_tdata <= {2'b00, on_wire.current_ma, on_wire.now_ms,
                             on_wire.duration_ms, on_wire.command, on_wire.channel};
                s_tuser <= on_wire.opcode;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall style changes now and then; one long hold-off
    // ------------------------------------------------------------------------
    int   results_taken = 0;
    int   hold_left = 0;
    bit   long_hold_done = 1'b0;
    int   stall_style = 0;
    int   style_left = 0;
    int   beat = 0;
    logic ready_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                results_taken++;
            // input is held off by s_tready while results back up
            if (!long_hold_done && results_taken == 400)
            begin
                hold_left = 250;
                long_hold_done = 1'b1;
            end
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            else
                style_left--;
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_style)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = (beat % 3 == 0);
                    default: ready_next = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    act_status_t got;
    act_status_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            got.forward_mask = m_tdata[7:0];
            got.reverse_mask = m_tdata[15:8];
            got.reported_states = m_tdata[31:16];
            got.channel_stopped = m_tdata[32];
            if (status_q.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = status_q.pop_front();
                if (got.forward_mask !== want.forward_mask)
                begin
                    $error("forward_mask: expected %h, got %h",
                           want.forward_mask, got.forward_mask);
                    errors++;
                end
                if (got.reverse_mask !== want.reverse_mask)
                begin
                    $error("reverse_mask: expected %h, got %h",
                           want.reverse_mask, got.reverse_mask);
                    errors++;
                end
                if (got.reported_states !== want.reported_states)
                begin
                    $error("reported_states: expected %h, got %h",
                           want.reported_states, got.reported_states);
                    errors++;
                end
                if (got.channel_stopped !== want.channel_stopped)
                begin
                    $error("channel_stopped: expected %b, got %b",
                           want.channel_stopped, got.channel_stopped);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_word(input logic op, input logic [2:0] ch, input logic [2:0] cmd,
                             input logic [31:0] dur, input logic [31:0] now,
                             input logic [15:0] cur);
        req_t w;
        w.opcode = op;
        w.channel = ch;
        w.command = cmd;
        w.duration_ms = dur;
        w.now_ms = now;
        w.current_ma = cur;
        word_q.push_back(w);
        n_queued++;
    endtask

    // Command one channel, then check it with times and currents near the edges.
    task automatic queue_move_sequence();
        logic [2:0]  ch;
        logic [2:0]  cmd;
        logic [31:0] t0;
        logic [31:0] dur;
        logic [31:0] elapsed;
        logic [15:0] cur;
        int          n_probe;
        ch = 3'($urandom_range(0, 7));
        cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
        // mostly moves, so the stop logic gets exercised
        if ($urandom_range(0, 3) != 0)
            cmd = 3'($urandom_range(0, 3));
        t0 = $urandom;
        case ($urandom_range(0, 5))
            0:       dur = '0;
            1:       dur = '1;
            2:       dur = $urandom_range(1, 50);
            3:       dur = $urandom_range(0, 1000);
            default: dur = $urandom;
        endcase
        push_word(OP_COMMAND, ch, cmd, dur, t0, 16'($urandom_range(0, 65535)));
        n_probe = $urandom_range(1, 3);
        for (int k = 0; k < n_probe; k++)
        begin
            case ($urandom_range(0, 6))
                0:       elapsed = dur - 32'd1;
                1:       elapsed = dur;
                2:       elapsed = dur + 32'd1;
                3:       elapsed = '0;
                4:       elapsed = '1;
                5:       elapsed = dur + $urandom_range(2, 20);
                default: elapsed = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       cur = limit_ma - 16'd1;
                1:       cur = limit_ma;
                2:       cur = limit_ma + 16'd1;
                3:       cur = '0;
                4:       cur = '1;
                default: cur = 16'($urandom_range(0, 65535));
            endcase
            push_word(OP_CHECK, ch, 3'($urandom_range(0, 7)), $urandom, t0 + elapsed, cur);
        end
    endtask

    task automatic queue_random_phase(input int n);
        int target;
        target = n_queued + n;
        while (n_queued < target)
        begin
            if ($urandom_range(0, 4) == 0)
                push_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), $urandom, $urandom,
                          16'($urandom_range(0, 65535)));
            else
                queue_move_sequence();
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (word_q.size() != 0 || s_tvalid || status_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_current_limit(input logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_ma = value;
        n_limits++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset limit of 100 mA
        push_word(OP_CHECK, 3'd0, 3'd0, 32'd0, 32'd0, 16'd0);               // check on off
        push_word(OP_COMMAND, 3'd0, MODE_RETRACT_FULL, 32'd0, 32'd0, 16'd0);
        push_word(OP_CHECK, 3'd0, 3'd0, 32'd0, 32'd5, 16'd100);             // at limit
        push_word(OP_CHECK, 3'd0, 3'd0, 32'd0, 32'd6, 16'd99);              // below
        push_word(OP_COMMAND, 3'd1, MODE_EXTEND_FULL, '1, '1, '1);
        push_word(OP_CHECK, 3'd1, 3'd7, '1, '1, 16'hFFFF);
        push_word(OP_CHECK, 3'd1, 3'd7, '1, '1, 16'd0);
        push_word(OP_COMMAND, 3'd2, MODE_RETRACT_TIMED, 32'd10, 32'hFFFF_FFFA, 16'd0);
        push_word(OP_CHECK, 3'd2, 3'd0, 32'd0, 32'd4, 16'd0);               // elapsed == length
        push_word(OP_CHECK, 3'd2, 3'd0, 32'd0, 32'd5, 16'd0);               // wrapped, past
        push_word(OP_COMMAND, 3'd3, MODE_EXTEND_TIMED, '1, 32'd0, 16'd0);
        push_word(OP_CHECK, 3'd3, 3'd0, 32'd0, '1, 16'd0);                  // max elapsed
        push_word(OP_COMMAND, 3'd4, MODE_ON, 32'd0, 32'd0, 16'd0);
        push_word(OP_CHECK, 3'd4, 3'd0, 32'd0, 32'd99, 16'd0);              // on ignores check
        push_word(OP_COMMAND, 3'd5, 3'd6, 32'd77, 32'd123, 16'd0);          // unknown mode
        push_word(OP_COMMAND, 3'd6, 3'd7, '1, '1, 16'd0);
        push_word(OP_CHECK, 3'd6, 3'd0, 32'd0, '1, 16'd0);
        push_word(OP_COMMAND, 3'd7, MODE_EXTEND_TIMED, 32'd0, 32'd1000, 16'd0);
        push_word(OP_CHECK, 3'd7, 3'd0, 32'd0, 32'd1000, 16'd0);            // zero length
        push_word(OP_CHECK, 3'd7, 3'd0, 32'd0, 32'd1001, 16'd0);
        push_word(OP_COMMAND, 3'd7, MODE_OFF, 32'd5, 32'd5, 16'd0);
        push_word(OP_COMMAND, 3'd2, MODE_RETRACT_TIMED, 32'd3, 32'd50, 16'd0);
        push_word(OP_CHECK, 3'd2, 3'd0, 32'd0, 32'd40, 16'd0);              // time ran back
        push_word(OP_COMMAND, 3'd5, MODE_RETRACT_FULL, 32'd0, 32'd0, 16'd0);

        queue_random_phase(300);
        set_current_limit(16'd0);
        queue_random_phase(250);
        set_current_limit(16'hFFFF);
        queue_random_phase(250);
        set_current_limit(16'd1);
        queue_random_phase(250);
        set_current_limit(16'($urandom_range(0, 65535)));
        queue_random_phase(250);
        set_current_limit(LIMIT_RESET);
        queue_random_phase(250);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d command and %0d check words, %0d full stops and %0d timed stops.",
                 n_commands, n_checks, n_full_stops, n_timed_stops);
        $display("Compared %0d result words over %0d current limit settings.",
                 n_results, n_limits + 1);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest stall pattern
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
